[hdl/assert_macros.svh]
// Assertion shorthands used by the checker.
// Each expects clk and rst in scope; rst disables the check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aph: assertion failed");

// Next-cycle implication.
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aph: assertion failed");

`endif

[hdl/aph_pkg.sv]
`timescale 1ns / 1ps
package aph_pkg;

  localparam int Q_FRAC     = 28;
  localparam int DIGIT_W    = 8;
  localparam int NUM_DIGITS = 4;
  localparam int DCNT_W     = 2;

  // 0.7 in Q4.28
  localparam logic signed [31:0] FB_GAIN = 32'sd187904819;

  localparam logic [63:0]        PI_Q30         = 64'd3373259426;
  localparam logic signed [63:0] QUARTER_PI_Q30 = 64'sd843314857;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 19;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_STAGES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 1'b1;

  localparam logic [3:0]  STAGES_MIN   = 4'd2;
  localparam logic [3:0]  STAGES_RESET = 4'd4;
  localparam logic [18:0] STEP_LOW     = 19'd4870;
  localparam logic [18:0] STEP_HIGH    = 19'd486950;
  localparam logic [18:0] STEP_RESET   = 19'd48695;

  typedef struct packed {
    logic               start;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } aph_mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] q;
  } aph_mul_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Round half up from Q56 to Q28 and saturate.
  function automatic logic signed [31:0] mulq_round(input logic signed [63:0] p);
    logic signed [63:0] r;
    r = (p + (64'sd1 <<< (Q_FRAC - 1))) >>> Q_FRAC;
    return sat32(r);
  endfunction

  // Shift-subtract long division, elaboration use only.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int j = 63; j >= 0; j--) begin
      r = {r[63:0], n[j]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // Allpass coefficient -tan(pi/4 - w) for table entry i, Q4.28.
  function automatic logic signed [31:0] coeff_for(input logic [63:0] i,
                                                   input logic [63:0] size);
    logic [63:0]        span;
    logic [63:0]        den;
    logic [63:0]        num;
    logic signed [63:0] w;
    logic signed [63:0] t;
    logic signed [63:0] term;
    logic signed [63:0] s;
    logic signed [63:0] c;
    logic signed [63:0] q;
    int k;
    span = size - 64'd1;
    den  = 64'd44100 * span;
    num  = PI_Q30 * (64'd200 * span + 64'd1600 * i);
    w    = signed'(udiv64(num + (den >> 1), den));
    t    = QUARTER_PI_Q30 - w;
    term = t;
    s    = t;
    c    = 64'sd1 <<< 30;
    for (k = 1; k <= 7; k++) begin
      term = signed'(udiv64(unsigned'((((term * t) >>> 30) * t) >>> 30),
                            64'(2 * k * (2 * k + 1))));
      s = k[0] ? s - term : s + term;
    end
    term = 64'sd1 <<< 30;
    for (k = 1; k <= 7; k++) begin
      term = signed'(udiv64(unsigned'((((term * t) >>> 30) * t) >>> 30),
                            64'((2 * k - 1) * (2 * k))));
      c = k[0] ? c - term : c + term;
    end
    if (s < 0) s = 0;
    if (c < 1) c = 1;
    q = signed'(udiv64(unsigned'(s <<< 28), unsigned'(c)));
    return 32'(-q);
  endfunction

endpackage

[hdl/aph_if.sv]
`timescale 1ns / 1ps
interface aph_in_if #(parameter int SAMPLE_WIDTH = 24);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           buffer_start;

  modport source (output valid, sample_in, buffer_start, input ready);
  modport sink (input valid, sample_in, buffer_start, output ready);
endinterface

interface aph_out_if #(parameter int SAMPLE_WIDTH = 24);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface

[hdl/aph_mul.sv]
`timescale 1ns / 1ps
// Q4.28 multiply, 8-bit digit of b per cycle, rounded and saturated.
module aph_mul import aph_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  aph_mul_req_t req,
  output aph_mul_rsp_t rsp
);

  logic signed [31:0]       a_reg;
  logic [31:0]              b_reg;
  logic signed [41:0]       acc;
  logic [DCNT_W-1:0]        cnt;
  logic                     busy;
  logic                     done;
  logic                     top_digit;
  logic signed [DIGIT_W:0]  d9;
  logic signed [40:0]       pp;
  logic signed [41:0]       sum;

  assign top_digit = (cnt == DCNT_W'(NUM_DIGITS - 1));
  assign d9  = {top_digit ? b_reg[DIGIT_W-1] : 1'b0, b_reg[DIGIT_W-1:0]};
  assign pp  = a_reg * d9;
  assign sum = acc + 42'(pp);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DCNT_W'(1);
        if (top_digit) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_reg <= req.a;
      b_reg <= req.b;
      acc   <= '0;
    end else if (busy) begin
      b_reg <= {sum[DIGIT_W-1:0], b_reg[31:DIGIT_W]};
      acc   <= sum >>> DIGIT_W;
    end
  end

  assign rsp.done = done;
  assign rsp.q    = mulq_round({acc[31:0], b_reg});

endmodule

[hdl/allpass_phaser_effect.sv]
`timescale 1ns / 1ps
// One item in work at a time: input is taken only in the idle state, after the result of
//   the last item has been loaded into the output register; the stages run in turn, each
//   on a pair of 8-bit digit multipliers (4 digits).
// Input is taken while a finished result still waits in the output register.
// Reset (rst, synchronous): LFO phase, feedback and stage delays cleared, num_stages 4,
//   phase_step 48695, no result pending. The coefficient table is constant.
module allpass_phaser_effect import aph_pkg::*; #(
  parameter int MAX_STAGES       = 12,
  parameter int COEFF_TABLE_SIZE = 1024,
  parameter int SAMPLE_WIDTH     = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  aph_in_if.sink                in_ch,
  aph_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ST_W   = (MAX_STAGES > 2) ? $clog2(MAX_STAGES) : 1;
  localparam int CMP_W  = (ST_W > 4) ? ST_W : 4;
  localparam int IDX_W  = $clog2(COEFF_TABLE_SIZE);
  localparam int SIZE_W = $clog2(COEFF_TABLE_SIZE + 1);
  localparam int PROD_W = 33 + SIZE_W;
  localparam logic [3:0] STAGES_RST =
    (MAX_STAGES < 4) ? 4'(MAX_STAGES) : STAGES_RESET;
  localparam logic signed [65:0] OUT_MAX = (66'sd1 <<< (SAMPLE_WIDTH - 1)) - 66'sd1;
  localparam logic signed [65:0] OUT_MIN = -(66'sd1 <<< (SAMPLE_WIDTH - 1));

  // Coefficient table, built at elaboration, read through a register.
  typedef logic signed [31:0] coeff_rom_t [COEFF_TABLE_SIZE];

  function automatic coeff_rom_t build_rom();
    coeff_rom_t r;
    for (int i = 0; i < COEFF_TABLE_SIZE; i++) begin
      r[i] = coeff_for(64'(i), 64'(COEFF_TABLE_SIZE));
    end
    return r;
  endfunction

  localparam coeff_rom_t COEFF_ROM = build_rom();

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ROM    = 6'b000010,
    S_FBWAIT = 6'b000100,
    S_STAGE  = 6'b001000,
    S_WAIT   = 6'b010000,
    S_MIX    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration and running state
  logic [3:0]  num_stages;
  logic [18:0] phase_step;
  logic [31:0] lfo_phase;
  logic signed [31:0] feedback;
  logic signed [31:0] x1 [MAX_STAGES];
  logic signed [31:0] y1 [MAX_STAGES];

  // Per-item working registers
  logic signed [31:0] in28;
  logic signed [31:0] s;
  logic signed [31:0] coeff;
  logic [IDX_W-1:0]   idx;
  logic [ST_W-1:0]    st;

  logic signed [SAMPLE_WIDTH-1:0] out_data;
  logic                           out_valid;

  logic               accept;
  logic               out_take;
  logic               out_load;
  logic               st_last;
  logic signed [63:0] in_wide;
  logic signed [31:0] in28_next;
  logic [32:0]        tri_d;
  logic [PROD_W-1:0]  idx_prod;
  logic [PROD_W-1:0]  idx_raw;
  logic [IDX_W-1:0]   idx_next;
  logic signed [33:0] stage_sum;
  logic signed [31:0] stage_n;
  logic signed [32:0] mix_sum;
  logic signed [32:0] mix;
  logic signed [65:0] o_wide;
  logic signed [SAMPLE_WIDTH-1:0] o_clamped;

  aph_mul_req_t req0;
  aph_mul_req_t req1;
  aph_mul_rsp_t rsp0;
  aph_mul_rsp_t rsp1;

  aph_mul u_mul0 (.clk(clk), .rst(rst), .req(req0), .rsp(rsp0));
  aph_mul u_mul1 (.clk(clk), .rst(rst), .req(req1), .rsp(rsp1));

  assign in_ch.ready   = (state == S_IDLE);
  assign accept        = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid;
  assign out_ch.sample_out = out_data;
  assign out_take      = out_valid && out_ch.ready;
  // Hold the finished result until the output register is free.
  assign out_load      = (state == S_MIX) && (!out_valid || out_ch.ready);

  // Q1.(SW-1) to Q4.28, floor shift; exact while SAMPLE_WIDTH is at most 29.
  assign in_wide   = 64'(in_ch.sample_in) <<< Q_FRAC;
  assign in28_next = 32'(in_wide >>> (SAMPLE_WIDTH - 1));

  // Triangle LFO: fold the phase, scale to the table, hold at the top entry.
  assign tri_d    = lfo_phase[31] ? (33'h1_0000_0000 - {1'b0, lfo_phase})
                                  : {1'b0, lfo_phase};
  assign idx_prod = PROD_W'(tri_d) * PROD_W'(COEFF_TABLE_SIZE);
  assign idx_raw  = idx_prod >> 31;
  assign idx_next = (idx_raw > PROD_W'(COEFF_TABLE_SIZE - 1))
                    ? IDX_W'(COEFF_TABLE_SIZE - 1) : idx_raw[IDX_W-1:0];

  // Multiplier requests: feedback gain first, then a*x and a*y1 per stage.
  always_comb begin
    req0.start = (state == S_ROM) || (state == S_STAGE);
    req0.a     = (state == S_ROM) ? feedback : coeff;
    req0.b     = (state == S_ROM) ? FB_GAIN : s;
    req1.start = (state == S_STAGE);
    req1.a     = coeff;
    req1.b     = y1[st];
  end

  // First-order allpass: y = a*x + x1 - a*y1, saturated.
  assign stage_sum = 34'(rsp0.q) + 34'(x1[st]) - 34'(rsp1.q);
  assign stage_n   = sat32(64'(stage_sum));
  assign st_last   = (CMP_W'(st) == CMP_W'(num_stages) - CMP_W'(1));

  // Dry/wet mix, back to the sample format with clamp.
  assign mix_sum = 33'(in28) + 33'(s);
  assign mix     = mix_sum >>> 1;
  assign o_wide  = ((66'(mix) <<< (SAMPLE_WIDTH - 1)) + (66'sd1 <<< (Q_FRAC - 1)))
                   >>> Q_FRAC;
  always_comb begin
    if (o_wide > OUT_MAX) begin
      o_clamped = OUT_MAX[SAMPLE_WIDTH-1:0];
    end else if (o_wide < OUT_MIN) begin
      o_clamped = OUT_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      o_clamped = o_wide[SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_ROM;
      S_ROM:    state_next = S_FBWAIT;
      S_FBWAIT: if (rsp0.done) state_next = S_STAGE;
      S_STAGE:  state_next = S_WAIT;
      S_WAIT: begin
        if (rsp0.done) state_next = st_last ? S_MIX : S_STAGE;
      end
      S_MIX:    if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration: clamp on write, ignore codes outside the list.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_stages <= STAGES_RST;
      phase_step <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_STAGES: begin
          if (cfg_data[3:0] < STAGES_MIN) begin
            num_stages <= STAGES_MIN;
          end else if (32'(cfg_data[3:0]) > MAX_STAGES) begin
            num_stages <= 4'(MAX_STAGES);
          end else begin
            num_stages <= cfg_data[3:0];
          end
        end
        REG_PHASE_STEP: begin
          if (cfg_data < STEP_LOW) begin
            phase_step <= STEP_LOW;
          end else if (cfg_data > STEP_HIGH) begin
            phase_step <= STEP_HIGH;
          end else begin
            phase_step <= cfg_data;
          end
        end
        default: ;
      endcase
    end
  end

  // LFO, feedback and stage delays
  always_ff @(posedge clk) begin
    if (rst) begin
      lfo_phase <= '0;
      feedback  <= '0;
      for (int i = 0; i < MAX_STAGES; i++) begin
        x1[i] <= '0;
        y1[i] <= '0;
      end
    end else begin
      if (accept) begin
        // Table index is taken from the current phase; advance afterwards.
        lfo_phase <= lfo_phase + 32'(phase_step);
        if (in_ch.buffer_start) begin
          for (int i = 0; i < MAX_STAGES; i++) begin
            x1[i] <= '0;
            y1[i] <= '0;
          end
        end
      end
      if ((state == S_WAIT) && rsp0.done) begin
        x1[st] <= s;
        y1[st] <= stage_n;
      end
      if (state == S_MIX) begin
        feedback <= s;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in28 <= in28_next;
      idx  <= idx_next;
    end
    if (state == S_ROM) begin
      coeff <= COEFF_ROM[idx];
    end
    if ((state == S_FBWAIT) && rsp0.done) begin
      s <= sat32(64'(in28) + 64'(rsp0.q));
    end
    if ((state == S_WAIT) && rsp0.done) begin
      s <= stage_n;
    end
    if (out_load) begin
      out_data <= o_clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if ((state == S_FBWAIT) && rsp0.done) begin
      st <= '0;
    end else if ((state == S_WAIT) && rsp0.done && !st_last) begin
      st <= st + ST_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[hdl/aph_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aph_checker #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_sample
);

  logic [1:0] pending;

  // Items taken but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  `AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `AST_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_sample))
  `AST_IMPL(a_reset_empty, $fell(rst), !out_valid)
  `AST_IMPL(a_no_invented, out_valid, pending != 2'd0)
  `AST_IMPL(a_one_in_work, pending == 2'd2, !in_ready)

endmodule

bind allpass_phaser_effect aph_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_aph_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_sample(out_ch.sample_out)
);

[sim/tb_allpass_phaser_effect.sv]
`timescale 1ns / 1ps
module tb_allpass_phaser_effect;
  import aph_pkg::*;

  localparam int  MAX_ST     = 12;
  localparam int  TABLE_SIZE = 1024;
  localparam int  SW         = 24;
  localparam int  LIMIT      = 2000000;
  // Worst-case latency of one item plus margin, used before config writes and at the end.
  localparam int  DRAIN_CYCLES = 100;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  aph_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
  aph_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

  allpass_phaser_effect #(
    .MAX_STAGES(MAX_ST), .COEFF_TABLE_SIZE(TABLE_SIZE), .SAMPLE_WIDTH(SW)
  ) uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // Phaser model state: stage count, LFO rate, accumulator, feedback and stage delays.
  int                 allpass_coeff [TABLE_SIZE];
  int unsigned        stage_count;
  int unsigned        lfo_step;
  int unsigned        lfo_acc;
  int                 cascade_fb;
  int                 x_hist [MAX_ST];
  int                 y_hist [MAX_ST];

  logic signed [SW-1:0] expected_out [$];
  int  fail_count;
  bit  steady;         // no idling on either side while set
  int  hold_req;       // receiver hold-off request, in cycles
  longint cycle_count;

  function automatic int sat32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return int'(x);
  endfunction

  function automatic int q28_mul(int a, int b);
    return sat32((longint'(a) * longint'(b) + (64'sd1 <<< 27)) >>> 28);
  endfunction

  // Coefficient -tan(pi/4 - w) from Taylor sine/cosine in Q30, truncated to Q28.
  function automatic int tan_coeff(int i);
    longint unsigned span, den, num;
    longint w, t, term, s, c;
    span = TABLE_SIZE - 1;
    den  = 64'd44100 * span;
    num  = PI_Q30 * (64'd200 * span + 64'd1600 * longint'(i));
    w    = longint'((num + den / 2) / den);
    t    = QUARTER_PI_Q30 - w;
    term = t;
    s    = t;
    c    = 64'sd1 <<< 30;
    for (int k = 1; k <= 7; k++) begin
      term = ((((term * t) >>> 30) * t) >>> 30) / longint'((2 * k) * (2 * k + 1));
      s = (k % 2 == 1) ? s - term : s + term;
    end
    term = 64'sd1 <<< 30;
    for (int k = 1; k <= 7; k++) begin
      term = ((((term * t) >>> 30) * t) >>> 30) / longint'((2 * k - 1) * (2 * k));
      c = (k % 2 == 1) ? c - term : c + term;
    end
    if (s < 0) s = 0;
    if (c < 1) c = 1;
    return int'(-((s <<< 28) / c));
  endfunction

  // Advance the model by one sample and return the mixed output.
  function automatic logic signed [SW-1:0] phaser_sample(logic signed [SW-1:0] smp,
                                                         logic clr);
    int in28, s, n, a;
    longint unsigned d, idx;
    longint mix, o;
    in28 = int'(longint'(smp) * 32);
    if (clr) begin
      for (int j = 0; j < MAX_ST; j++) begin
        x_hist[j] = 0;
        y_hist[j] = 0;
      end
    end
    d = (lfo_acc < 32'h80000000) ? longint'(lfo_acc) : (64'd1 << 32) - lfo_acc;
    idx = (d * TABLE_SIZE) >> 31;
    if (idx > TABLE_SIZE - 1) idx = TABLE_SIZE - 1;
    a = allpass_coeff[idx];
    s = sat32(longint'(in28) + q28_mul(cascade_fb, FB_GAIN));
    for (int j = 0; j < stage_count; j++) begin
      n = sat32(longint'(q28_mul(a, s)) + x_hist[j] - q28_mul(a, y_hist[j]));
      x_hist[j] = s;
      y_hist[j] = n;
      s = n;
    end
    cascade_fb = s;
    mix = (longint'(in28) + longint'(s)) >>> 1;
    o = (mix * (64'sd1 <<< (SW - 1)) + (64'sd1 <<< 27)) >>> 28;
    if (o > (64'sd1 <<< (SW - 1)) - 1) o = (64'sd1 <<< (SW - 1)) - 1;
    if (o < -(64'sd1 <<< (SW - 1))) o = -(64'sd1 <<< (SW - 1));
    lfo_acc = lfo_acc + lfo_step;
    return o[SW-1:0];
  endfunction

  // Wait for the block to drain, then write one register and mirror it in the model.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    int unsigned v;
    // Withdraw any standing offer so the last sample is not taken twice.
    in_ch.valid <= 1'b0;
    wait (expected_out.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NUM_STAGES) begin
      v = val & 4'hF;
      if (v < 2) v = 2;
      if (v > MAX_ST) v = MAX_ST;
      stage_count = v;
    end else if (idx == REG_PHASE_STEP) begin
      v = val;
      if (v < STEP_LOW) v = STEP_LOW;
      if (v > STEP_HIGH) v = STEP_HIGH;
      lfo_step = v;
    end
  endtask

  // Offer one sample after a random gap, none in steady mode; predict it on the accepting edge.
  // Valid stays high between back-to-back transactions.
  task automatic send_sample(logic signed [SW-1:0] smp, logic clr);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample_in    <= smp;
    in_ch.buffer_start <= clr;
    do @(posedge clk); while (!in_ch.ready);
    expected_out.push_back(phaser_sample(smp, clr));
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [SW-1:0] random_sample();
    logic signed [SW-1:0] r;
    r = SW'($urandom);
    // Mostly moderate levels so the cascade is exercised without constant clipping.
    if ($urandom_range(0, 2) != 0) r = r >>> $urandom_range(1, 12);
    return r;
  endfunction

  // Field extremes, buffer starts and register clamping.
  task automatic test_directed();
    send_sample(24'sh7fffff, 1'b1);
    send_sample(24'sh7fffff, 1'b0);
    send_sample(-24'sh800000, 1'b0);
    send_sample(-24'sh800000, 1'b0);
    send_sample(24'sh000000, 1'b0);
    send_sample(-24'sh000001, 1'b0);
    send_sample(24'sh000001, 1'b1);
    send_sample(24'sh555555, 1'b0);
    send_sample(-24'sh2aaaab, 1'b0);
    drop_valid();
    // Stage count below range clamps to two.
    write_reg(REG_NUM_STAGES, 19'd0);
    send_sample(24'sh400000, 1'b0);
    send_sample(-24'sh400000, 1'b0);
    write_reg(REG_NUM_STAGES, 19'd1);
    send_sample(24'sh123456, 1'b0);
    drop_valid();
    // Above range clamps to the maximum; change mid-buffer without a clear.
    write_reg(REG_NUM_STAGES, 19'h7fff);
    send_sample(24'sh7fffff, 1'b0);
    send_sample(-24'sh800000, 1'b0);
    write_reg(REG_NUM_STAGES, 19'd3);
    send_sample(24'sh0f0f0f, 1'b0);
    write_reg(REG_NUM_STAGES, 19'd12);
    send_sample(-24'sh0f0f0f, 1'b0);
    drop_valid();
    // LFO rate clamping at both ends.
    write_reg(REG_PHASE_STEP, 19'd0);
    send_sample(24'sh200000, 1'b1);
    send_sample(24'sh200000, 1'b0);
    write_reg(REG_PHASE_STEP, 19'h7ffff);
    send_sample(-24'sh200000, 1'b0);
    send_sample(-24'sh200000, 1'b0);
    send_sample(24'sh7fffff, 1'b0);
    drop_valid();
  endtask

  // Buffers of random length with random content under the current settings.
  task automatic test_random(int count);
    int left;
    left = 0;
    for (int k = 0; k < count; k++) begin
      if (left == 0) left = $urandom_range(8, 80);
      send_sample(random_sample(), (left == 1) || ($urandom_range(0, 199) == 0));
      left--;
    end
    drop_valid();
  endtask

  // Hold the receiver off for a long stretch while samples keep coming.
  task automatic test_backpressure();
    hold_req = 400;
    for (int k = 0; k < 24; k++) send_sample(random_sample(), k == 0);
    drop_valid();
  endtask

  task automatic test_steady();
    steady = 1'b1;
    for (int k = 0; k < 60; k++) send_sample(random_sample(), k == 0);
    drop_valid();
    steady = 1'b0;
  endtask

  // Receiver: random stalls after each transaction, plus requested hold-offs.
  int hold_left;
  int stall_left;
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (out_ch.valid && out_ch.ready) begin
        stall_left = steady ? 0 : $urandom_range(0, 3);
        out_ch.ready <= (stall_left == 0);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare every result transaction against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_out.size() == 0) begin
        $error("sample_out: unexpected result %0d", out_ch.sample_out);
        fail_count++;
      end else begin
        if (out_ch.sample_out !== expected_out[0]) begin
          $error("sample_out: expected %0d, got %0d", expected_out[0], out_ch.sample_out);
          fail_count++;
        end
        void'(expected_out.pop_front());
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.sample_in    = '0;
    in_ch.buffer_start = 1'b0;
    out_ch.ready       = 1'b0;
    fail_count  = 0;
    steady      = 1'b0;
    hold_req    = 0;
    hold_left   = 0;
    stall_left  = 0;
    cycle_count = 0;
    for (int i = 0; i < TABLE_SIZE; i++) allpass_coeff[i] = tan_coeff(i);
    stage_count = STAGES_RESET;
    lfo_step    = STEP_RESET;
    lfo_acc     = 0;
    cascade_fb  = 0;
    for (int j = 0; j < MAX_ST; j++) begin
      x_hist[j] = 0;
      y_hist[j] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_steady();
    test_backpressure();
    // Walk through several settings, the extremes among them.
    write_reg(REG_NUM_STAGES, 19'd4);
    write_reg(REG_PHASE_STEP, STEP_RESET);
    test_random(300);
    write_reg(REG_NUM_STAGES, 19'd2);
    write_reg(REG_PHASE_STEP, STEP_HIGH);
    test_random(300);
    write_reg(REG_NUM_STAGES, 19'd12);
    write_reg(REG_PHASE_STEP, STEP_LOW);
    test_random(250);
    write_reg(REG_NUM_STAGES, CFG_DATA_W'($urandom_range(0, 15)));
    write_reg(REG_PHASE_STEP, CFG_DATA_W'($urandom));
    test_random(300);
    write_reg(REG_NUM_STAGES, 19'd7);
    write_reg(REG_PHASE_STEP, CFG_DATA_W'($urandom_range(STEP_LOW, STEP_HIGH)));
    test_random(350);

    wait (expected_out.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
